// ===== hw/rtl/cke_pkg.sv =====
// Shared constants and register codes for the canonical k-mer extractor.
// No dependencies; used by canonical_kmer_extractor_top and cke_canon.
`timescale 1ns / 1ps

package cke_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_KMER_SIZE    = 1'b0,
    REG_MAX_READ_LEN = 1'b1
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned KSIZE_W    = 5;

  localparam logic [KSIZE_W-1:0]    KMER_SIZE_RESET    = 5'd31;
  localparam logic [CFG_DATA_W-1:0] MAX_READ_LEN_RESET = 16'd250;

  // Neighbor code meaning "no base", and the largest base code (T)
  localparam logic [2:0] BASE_NONE = 3'd4;
  localparam logic [2:0] BASE_MAX  = 3'd3;

endpackage

// ===== hw/rtl/canonical_kmer_extractor_top.sv =====
// Canonical k-mer extractor: one base item accepted per cycle, every k-mer of a
// read is given with its canonical neighbors. Each item's results are computed
// from the rolling words in the same cycle and written into a four-entry output
// queue, which hands out one result per cycle while out_ready is high. An item
// that ends a read can give two results, so the input waits only while the
// queue has fewer than two free entries; with out_ready held high the sustained
// rate is one item per cycle for ordinary bases. There is no clearing pass
// after reset. Depends on cke_pkg, cke_canon and cke_outq.
`timescale 1ns / 1ps

module canonical_kmer_extractor_top #(
  parameter int unsigned MAX_K         = 31,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [0:0]                       wr_index,
  input  logic [cke_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       base,
  input  logic                             read_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2*MAX_K-1:0]               kmer,
  output logic [2:0]                       left_nbr,
  output logic [2:0]                       right_nbr,
  output logic                             last_kmer
);

  localparam int unsigned WORD_W = 2 * MAX_K;
  localparam int unsigned CMP_W  = (POSITION_BITS > cke_pkg::CFG_DATA_W) ?
                                   POSITION_BITS : cke_pkg::CFG_DATA_W;
  localparam int unsigned RES_W  = WORD_W + 7;
  localparam logic [cke_pkg::KSIZE_W-1:0] K_MAX = cke_pkg::KSIZE_W'(MAX_K);

  // configuration
  logic [cke_pkg::KSIZE_W-1:0]    kmer_size;
  logic [cke_pkg::CFG_DATA_W-1:0] max_read_len;

  // read state
  logic [WORD_W-1:0]        forward_word;
  logic [WORD_W-1:0]        revcomp_word;
  logic [1:0]               dropped_base;
  logic [POSITION_BITS-1:0] base_position;
  logic                     past_limit;

  logic [WORD_W-1:0]        forward_word_next;
  logic [WORD_W-1:0]        revcomp_word_next;
  logic [1:0]               dropped_base_next;
  logic [POSITION_BITS-1:0] base_position_next;
  logic                     past_limit_next;

  logic [cke_pkg::KSIZE_W-1:0] k_eff;
  logic [5:0]                  shift_2k;
  logic [5:0]                  shift_top;
  logic [WORD_W-1:0]           kmask;
  logic [CMP_W-1:0]            pos_ext;
  logic [CMP_W-1:0]            pos_inc_ext;
  logic [CMP_W-1:0]            k_ext;
  logic [CMP_W-1:0]            mrl_ext;
  logic [POSITION_BITS-1:0]    pos_inc;
  logic                        use_base;
  logic                        emit_step;
  logic                        emit_end;
  logic [2:0]                  lb_step;
  logic [2:0]                  lb_end;
  logic [WORD_W-1:0]           fwd_shift;
  logic [WORD_W-1:0]           rev_shift;
  logic [1:0]                  drop_shift;
  logic [WORD_W-1:0]           fwd_end;
  logic [WORD_W-1:0]           rev_end;
  logic [1:0]                  drop_end;
  logic [CMP_W-1:0]            pos_end_ext;
  logic                        accept;

  logic [WORD_W-1:0] kmer_s, kmer_e;
  logic [2:0]        left_s, right_s, left_e, right_e;
  logic [RES_W-1:0]  res_step, res_end, q_data_a, q_data_b, q_out;
  logic              push_a, push_b;

  always_comb begin
    if (kmer_size == '0) begin
      k_eff = cke_pkg::KSIZE_W'(1);
    end else if (kmer_size > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = kmer_size;
    end
  end

  assign shift_2k  = {k_eff, 1'b0};
  assign shift_top = shift_2k - 6'd2;
  assign kmask     = ~({WORD_W{1'b1}} << shift_2k);

  assign pos_inc     = base_position + 1'b1;
  assign pos_ext     = CMP_W'(base_position);
  assign pos_inc_ext = CMP_W'(pos_inc);
  assign k_ext       = CMP_W'(k_eff);
  assign mrl_ext     = CMP_W'(max_read_len);

  assign use_base  = !past_limit && (pos_ext < mrl_ext) && (base_position != '1);
  assign emit_step = use_base && (pos_ext >= k_ext);
  assign lb_step   = (pos_ext > k_ext) ? {1'b0, dropped_base} : cke_pkg::BASE_NONE;

  // roll both words by one base
  assign fwd_shift  = ((forward_word << 2) | WORD_W'(base)) & kmask;
  assign rev_shift  = ((revcomp_word >> 2) |
                       (WORD_W'(2'd3 - base) << shift_top)) & kmask;
  assign drop_shift = 2'(forward_word >> shift_top);

  // window seen by the end-of-read result
  assign fwd_end     = use_base ? fwd_shift : forward_word;
  assign rev_end     = use_base ? rev_shift : revcomp_word;
  assign drop_end    = use_base ? drop_shift : dropped_base;
  assign pos_end_ext = use_base ? pos_inc_ext : pos_ext;
  assign emit_end    = read_end && (pos_end_ext >= k_ext);
  assign lb_end      = (pos_end_ext > k_ext) ? {1'b0, drop_end} : cke_pkg::BASE_NONE;

  always_comb begin
    forward_word_next  = forward_word;
    revcomp_word_next  = revcomp_word;
    dropped_base_next  = dropped_base;
    base_position_next = base_position;
    past_limit_next    = 1'b1;
    if (use_base) begin
      forward_word_next  = fwd_shift;
      revcomp_word_next  = rev_shift;
      dropped_base_next  = drop_shift;
      base_position_next = pos_inc;
      past_limit_next    = (pos_inc_ext >= mrl_ext) || (pos_inc == '1);
    end
    if (read_end) begin
      forward_word_next  = '0;
      revcomp_word_next  = '0;
      dropped_base_next  = '0;
      base_position_next = '0;
      past_limit_next    = 1'b0;
    end
  end

  cke_canon #(.WORD_W(WORD_W)) u_canon_step (
    .fwd       (forward_word),
    .rev       (revcomp_word),
    .lb        (lb_step),
    .rb        ({1'b0, base}),
    .kmer      (kmer_s),
    .left_nbr  (left_s),
    .right_nbr (right_s)
  );

  cke_canon #(.WORD_W(WORD_W)) u_canon_end (
    .fwd       (fwd_end),
    .rev       (rev_end),
    .lb        (lb_end),
    .rb        (cke_pkg::BASE_NONE),
    .kmer      (kmer_e),
    .left_nbr  (left_e),
    .right_nbr (right_e)
  );

  assign res_step = {kmer_s, left_s, right_s, 1'b0};
  assign res_end  = {kmer_e, left_e, right_e, 1'b1};

  assign accept   = in_valid && in_ready;
  // pack results into the queue in order, first free slot first
  assign push_a   = accept && (emit_step || emit_end);
  assign push_b   = accept && emit_step && emit_end;
  assign q_data_a = emit_step ? res_step : res_end;
  assign q_data_b = res_end;

  cke_outq #(.DATA_W(RES_W)) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_a    (push_a),
    .push_b    (push_b),
    .data_a    (q_data_a),
    .data_b    (q_data_b),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_out)
  );

  assign kmer      = q_out[RES_W-1:7];
  assign left_nbr  = q_out[6:4];
  assign right_nbr = q_out[3:1];
  assign last_kmer = q_out[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_size     <= cke_pkg::KMER_SIZE_RESET;
      max_read_len  <= cke_pkg::MAX_READ_LEN_RESET;
      forward_word  <= '0;
      revcomp_word  <= '0;
      dropped_base  <= '0;
      base_position <= '0;
      past_limit    <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          cke_pkg::REG_KMER_SIZE:    kmer_size    <= wr_data[cke_pkg::KSIZE_W-1:0];
          cke_pkg::REG_MAX_READ_LEN: max_read_len <= wr_data;
          default: ;
        endcase
      end
      if (accept) begin
        forward_word  <= forward_word_next;
        revcomp_word  <= revcomp_word_next;
        dropped_base  <= dropped_base_next;
        base_position <= base_position_next;
        past_limit    <= past_limit_next;
      end
    end
  end

endmodule

// ===== hw/rtl/cke_canon.sv =====
// Picks the canonical orientation of one k-mer window and orients its neighbors.
// Depends on cke_pkg for the neighbor codes.
`timescale 1ns / 1ps

module cke_canon #(
  parameter int unsigned WORD_W = 62
) (
  input  logic [WORD_W-1:0] fwd,
  input  logic [WORD_W-1:0] rev,
  input  logic [2:0]        lb,
  input  logic [2:0]        rb,
  output logic [WORD_W-1:0] kmer,
  output logic [2:0]        left_nbr,
  output logic [2:0]        right_nbr
);

  logic use_fwd;

  assign use_fwd = (fwd <= rev);

  always_comb begin
    if (use_fwd) begin
      kmer      = fwd;
      left_nbr  = lb;
      right_nbr = rb;
    end else begin
      // reverse strand: swap and complement the neighbors
      kmer      = rev;
      left_nbr  = (rb == cke_pkg::BASE_NONE) ? cke_pkg::BASE_NONE : cke_pkg::BASE_MAX - rb;
      right_nbr = (lb == cke_pkg::BASE_NONE) ? cke_pkg::BASE_NONE : cke_pkg::BASE_MAX - lb;
    end
  end

endmodule

// ===== hw/rtl/cke_outq.sv =====
// Four-entry result queue that takes up to two results per cycle and gives one
// per cycle while out_ready is high. No package dependency.
`timescale 1ns / 1ps

module cke_outq #(
  parameter int unsigned DATA_W = 69
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_a,
  input  logic              push_b,
  input  logic [DATA_W-1:0] data_a,
  input  logic [DATA_W-1:0] data_b,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = 2;

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;
  logic [PTR_W:0]    count_next;
  logic              pop;
  logic [PTR_W:0]    push_cnt;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  // accept an item only when both of its possible results fit
  assign room      = (count <= (PTR_W+1)'(DEPTH - 2));
  assign push_cnt  = (PTR_W+1)'(push_a) + (PTR_W+1)'(push_b);

  always_comb begin
    count_next = count + push_cnt - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt[PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      entries[wr_ptr] <= data_a;
    end
    if (push_b) begin
      entries[wr_ptr + 1'b1] <= data_b;
    end
  end

endmodule
